// ----- hdl/env_sensor_compensation_defines.svh -----
// Assertion macros used by the checker file esc_chk.sv.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ESC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ESC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/esc_pkg.sv -----
package esc_pkg;

  localparam int FRAC_BITS = 32;
  localparam int MUL_LAT   = 4;
  // Dividend width: |numerator| <= 2^63, 6250 < 2^13, plus the fraction shift.
  localparam int NUM_W     = 76 + FRAC_BITS;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [63:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {63{1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {63{1'b0}}};
  localparam fix_t ONE     = fix_t'(64'd1 << FRAC_BITS);
  localparam logic [63:0] DIV_THR = (64'd1 << FRAC_BITS) / 64'd1000000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP       = 3'd0,
    REG_PRESS_LOW  = 3'd1,
    REG_PRESS_HIGH = 3'd2,
    REG_PRESS_NINE = 3'd3,
    REG_HUM        = 3'd4
  } reg_idx_e;

  function automatic fix_t sat_wide(logic signed [127:0] w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = FIX_MAX;
    lo = FIX_MIN;
    if (w > hi) return FIX_MAX;
    if (w < lo) return FIX_MIN;
    return fix_t'(w[63:0]);
  endfunction

  function automatic fix_t sadd(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? FIX_MIN : FIX_MAX;
    return fix_t'(s[63:0]);
  endfunction

  // Negating the most negative value is replaced by the most positive one.
  function automatic fix_t ssub(fix_t a, fix_t b);
    return sadd(a, (b == FIX_MIN) ? FIX_MAX : -b);
  endfunction

  function automatic logic [63:0] mag(fix_t a);
    logic [63:0] u;
    u = a;
    return u[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic fix_t qi(fix_t k);
    logic signed [127:0] w;
    w = k;
    w = w <<< FRAC_BITS;
    return sat_wide(w);
  endfunction

endpackage

// ----- hdl/esc_if.sv -----
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;
  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_out;
  logic [24:0]        pressure_out;
  logic               pressure_valid;
  logic signed [17:0] humidity_out;
  modport source (output valid, temperature_out, pressure_out, pressure_valid,
                  humidity_out, input ready);
  modport sink (input valid, temperature_out, pressure_out, pressure_valid,
                humidity_out, output ready);
endinterface

interface esc_cfg_if;
  import esc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/esc_mul.sv -----
module esc_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  esc_pkg::fix_t a_i,
  input  esc_pkg::fix_t b_i,
  input  logic [6:0]    shift_i,
  output esc_pkg::fix_t p_o
);
  import esc_pkg::*;

  logic         neg1_q, neg2_q, neg3_q;
  logic [63:0]  am_q, bm_q;
  logic [63:0]  pp_q [4];
  logic [127:0] prod_q;
  logic [127:0] sum_d, shifted, mask, qmag;
  logic         dropped;
  fix_t         p_d;

  // Floor of the signed product over 2^shift, saturated to 64 bits.
  always_comb begin
    sum_d = {pp_q[3], 64'd0} + {32'd0, pp_q[1], 32'd0} + {32'd0, pp_q[2], 32'd0}
          + {64'd0, pp_q[0]};
    shifted = prod_q >> shift_i;
    mask    = (128'd1 << shift_i) - 128'd1;
    dropped = |(prod_q & mask);
    qmag    = shifted + {127'd0, neg3_q & dropped};
    if (!neg3_q) begin
      p_d = (|qmag[127:63]) ? FIX_MAX : fix_t'(qmag[63:0]);
    end else begin
      p_d = (|qmag[127:63]) ? FIX_MIN : fix_t'(~qmag[63:0] + 64'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= a_i[63] ^ b_i[63];
      am_q    <= mag(a_i);
      bm_q    <= mag(b_i);
      neg2_q  <= neg1_q;
      pp_q[0] <= am_q[31:0] * bm_q[31:0];
      pp_q[1] <= am_q[31:0] * bm_q[63:32];
      pp_q[2] <= am_q[63:32] * bm_q[31:0];
      pp_q[3] <= am_q[63:32] * bm_q[63:32];
      neg3_q  <= neg2_q;
      prod_q  <= sum_d;
      p_o     <= p_d;
    end
  end

endmodule

// ----- hdl/esc_div.sv -----
module esc_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [esc_pkg::NUM_W-1:0] num_i,
  input  logic [63:0]               den_i,
  output logic [esc_pkg::NUM_W-1:0] quo_o
);
  import esc_pkg::*;

  // One restoring step per stage; dividend bits leave at the top while
  // quotient bits enter at the bottom of the same word.
  logic [63:0]      rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [63:0]      den_q [NUM_W-1];
  logic [63:0]      rem_d [NUM_W];
  logic [NUM_W-1:0] nq_d  [NUM_W];

  always_comb begin
    logic [63:0]      rin, din, trial;
    logic [NUM_W-1:0] nin;
    for (int i = 0; i < NUM_W; i++) begin
      if (i == 0) begin
        rin = '0;
        nin = num_i;
        din = den_i;
      end else begin
        rin = rem_q[i-1];
        nin = nq_q[i-1];
        din = den_q[i-1];
      end
      trial = {rin[62:0], nin[NUM_W-1]};
      if (trial >= din) begin
        rem_d[i] = trial - din;
        nq_d[i]  = {nin[NUM_W-2:0], 1'b1};
      end else begin
        rem_d[i] = trial;
        nq_d[i]  = {nin[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_W; i++) begin
        rem_q[i] <= rem_d[i];
        nq_q[i]  <= nq_d[i];
      end
      den_q[0] <= den_i;
      for (int i = 1; i < NUM_W - 1; i++) den_q[i] <= den_q[i-1];
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

// ----- hdl/env_sensor_compensation.sv -----
// Channel  Dir  Transfer when       Contents
// cfg_i    in   valid && ready      register index, 64-bit write data
// in_i     in   valid && ready      raw temperature, pressure, humidity
// out_o    out  valid && ready      temperature, pressure, pressure valid, humidity
//
// One item enters per cycle while the output is not held; each result appears
// after passing the whole pipeline, most of whose depth is the pressure
// divider, one quotient bit per stage.
// All stages share one enable: a held output stalls the whole pipeline.
// Reset clears the valid bits and the coefficient registers.
module env_sensor_compensation (
  input logic clk_i,
  input logic rst_ni,
  esc_cfg_if.sink   cfg_i,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);
  import esc_pkg::*;

  localparam int S_TF    = 2 * MUL_LAT + 2;
  localparam int S_V1A   = S_TF + 1;
  localparam int S_TOUT  = S_V1A + 2;
  localparam int S_V2    = S_V1A + 2 * MUL_LAT + 2;
  localparam int S_PR0   = S_V2 + 1;
  localparam int S_V1    = S_V2 + MUL_LAT;
  localparam int S_DIVST = S_V1 + 1;
  localparam int S_QUO   = S_DIVST + 1 + NUM_W;
  localparam int S_PR    = S_QUO + 1;
  localparam int S_PS2   = S_PR + 2 * MUL_LAT + 2;
  localparam int S_PS3   = S_PS2 + 1;
  localparam int S_LAST  = S_PS3 + 1;
  localparam int S_HX1   = S_V1A + MUL_LAT + 1;
  localparam int S_HA    = S_HX1 + 1;
  localparam int S_X4    = S_HX1 + 2 * MUL_LAT + 1;
  localparam int S_HUM   = S_X4 + MUL_LAT;
  localparam int S_X5    = S_HUM + MUL_LAT + 1;
  localparam int S_HOUT  = S_X5 + MUL_LAT + 1;

  // Coefficient registers
  logic [47:0] temp_coeffs_q;
  logic [63:0] press_low_q, press_high_q, hum_coeffs_q;
  logic [15:0] press_nine_q;

  fix_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;

  assign t1 = fix_t'(temp_coeffs_q[15:0]);
  assign t2 = fix_t'(signed'(temp_coeffs_q[31:16]));
  assign t3 = fix_t'(signed'(temp_coeffs_q[47:32]));
  assign p1 = fix_t'(press_low_q[15:0]);
  assign p2 = fix_t'(signed'(press_low_q[31:16]));
  assign p3 = fix_t'(signed'(press_low_q[47:32]));
  assign p4 = fix_t'(signed'(press_low_q[63:48]));
  assign p5 = fix_t'(signed'(press_high_q[15:0]));
  assign p6 = fix_t'(signed'(press_high_q[31:16]));
  assign p7 = fix_t'(signed'(press_high_q[47:32]));
  assign p8 = fix_t'(signed'(press_high_q[63:48]));
  assign p9 = fix_t'(signed'(press_nine_q));
  assign h1 = fix_t'(hum_coeffs_q[7:0]);
  assign h2 = fix_t'(signed'(hum_coeffs_q[23:8]));
  assign h3 = fix_t'(hum_coeffs_q[31:24]);
  assign h4 = fix_t'(signed'(hum_coeffs_q[43:32]));
  assign h5 = fix_t'(signed'(hum_coeffs_q[55:44]));
  assign h6 = fix_t'(signed'(hum_coeffs_q[63:56]));

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_low_q   <= '0;
      press_high_q  <= '0;
      press_nine_q  <= '0;
      hum_coeffs_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_TEMP:       temp_coeffs_q <= cfg_i.data[47:0];
        REG_PRESS_LOW:  press_low_q   <= cfg_i.data;
        REG_PRESS_HIGH: press_high_q  <= cfg_i.data;
        REG_PRESS_NINE: press_nine_q  <= cfg_i.data[15:0];
        REG_HUM:        hum_coeffs_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic vld_q [S_LAST+1];
  logic en;

  assign en         = !vld_q[S_LAST] || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = vld_q[S_LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= S_LAST; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i <= S_LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Datapath registers
  logic [19:0] rt_q, rp_q;
  logic [15:0] rh_q;
  fix_t a0_q, b0_q, tf_q, v1a_q, h_q;
  logic [18:0] ty_q;
  logic [37:0] tp_q;
  logic [15:0] temp_q;
  fix_t v2s_q, v1s_q, v2_q, v1t_q, pr0_q;
  logic dvld_q, neg_q;
  logic [63:0] den_q, den27_q, pm_q;
  logic [NUM_W-1:0] num_q;
  fix_t pr_q, ps1_q, ps2_q, ps3_q;
  fix_t x1_q, x2_q, m6d_q, ha_q, x3_q, x5_q;
  logic [17:0] hout_q;
  logic signed [15:0] tout_q;
  logic [24:0] pout_q;
  logic pvld_q;
  logic signed [17:0] hfin_q;

  // Delay lines that align operands of later stages
  fix_t        at_dly_q   [MUL_LAT];
  fix_t        p5m_dly_q  [MUL_LAT];
  fix_t        p2m_dly_q  [MUL_LAT];
  fix_t        bq_dly_q   [MUL_LAT];
  logic [19:0] rp_dly_q   [S_V2];
  logic [15:0] rh_dly_q   [S_HX1];
  fix_t        pr0_dly_q  [S_V1-S_PR0];
  logic        neg_dly_q  [S_QUO-S_DIVST];
  logic        dvld_dly_q [S_PS3-S_DIVST];
  fix_t        pr_dly_q   [S_PS2-S_PR];
  fix_t        ha_dly_q   [S_X4-S_HA];
  fix_t        hum_dly_q  [S_X5-S_HUM];
  logic [15:0] tmp_dly_q  [S_PS3-S_TOUT];
  logic [17:0] hout_dly_q [S_PS3-S_HOUT];

  // Multiplier outputs
  fix_t at_w, sq_w, bt_w, m47_w, v2a_w, p5m_w, m51_w, ap_w, p2m_w, v1_w;
  fix_t pp_w, aq_w, bq_w, mh5_w, mh3_w, mh6_w, mx3_w, x4_w, hum_w, mh1_w, hum2_w;
  logic [NUM_W-1:0] quo_w;

  esc_mul u_mul_at  (.clk_i, .en_i(en), .a_i(a0_q), .b_i(t2), .shift_i(7'd0), .p_o(at_w));
  esc_mul u_mul_sq  (.clk_i, .en_i(en), .a_i(b0_q), .b_i(b0_q),
                     .shift_i(7'(FRAC_BITS)), .p_o(sq_w));
  esc_mul u_mul_bt  (.clk_i, .en_i(en), .a_i(sq_w), .b_i(t3), .shift_i(7'd0), .p_o(bt_w));
  esc_mul u_mul_47  (.clk_i, .en_i(en), .a_i(v1a_q), .b_i(v1a_q),
                     .shift_i(7'(FRAC_BITS + 15)), .p_o(m47_w));
  esc_mul u_mul_p6  (.clk_i, .en_i(en), .a_i(m47_w), .b_i(p6), .shift_i(7'd0), .p_o(v2a_w));
  esc_mul u_mul_p5  (.clk_i, .en_i(en), .a_i(v1a_q), .b_i(p5 <<< 1), .shift_i(7'd0),
                     .p_o(p5m_w));
  esc_mul u_mul_51  (.clk_i, .en_i(en), .a_i(v1a_q), .b_i(v1a_q),
                     .shift_i(7'(FRAC_BITS + 19)), .p_o(m51_w));
  esc_mul u_mul_p3  (.clk_i, .en_i(en), .a_i(m51_w), .b_i(p3), .shift_i(7'd0), .p_o(ap_w));
  esc_mul u_mul_p2  (.clk_i, .en_i(en), .a_i(v1a_q), .b_i(p2), .shift_i(7'd0), .p_o(p2m_w));
  esc_mul u_mul_p1  (.clk_i, .en_i(en), .a_i(v1t_q), .b_i(p1), .shift_i(7'd0), .p_o(v1_w));
  esc_mul u_mul_pp  (.clk_i, .en_i(en), .a_i(pr_q), .b_i(pr_q),
                     .shift_i(7'(FRAC_BITS + 31)), .p_o(pp_w));
  esc_mul u_mul_p9  (.clk_i, .en_i(en), .a_i(pp_w), .b_i(p9), .shift_i(7'd0), .p_o(aq_w));
  esc_mul u_mul_p8  (.clk_i, .en_i(en), .a_i(pr_q), .b_i(p8), .shift_i(7'd15), .p_o(bq_w));
  esc_mul u_mul_h5  (.clk_i, .en_i(en), .a_i(h_q), .b_i(h5), .shift_i(7'd14), .p_o(mh5_w));
  esc_mul u_mul_h3  (.clk_i, .en_i(en), .a_i(h_q), .b_i(h3), .shift_i(7'd26), .p_o(mh3_w));
  esc_mul u_mul_h6  (.clk_i, .en_i(en), .a_i(h_q), .b_i(h6), .shift_i(7'd26), .p_o(mh6_w));
  esc_mul u_mul_x3  (.clk_i, .en_i(en), .a_i(m6d_q), .b_i(x2_q),
                     .shift_i(7'(FRAC_BITS)), .p_o(mx3_w));
  esc_mul u_mul_h2  (.clk_i, .en_i(en), .a_i(x3_q), .b_i(h2), .shift_i(7'd16), .p_o(x4_w));
  esc_mul u_mul_hum (.clk_i, .en_i(en), .a_i(ha_dly_q[S_X4-S_HA-1]), .b_i(x4_w),
                     .shift_i(7'(FRAC_BITS)), .p_o(hum_w));
  esc_mul u_mul_h1  (.clk_i, .en_i(en), .a_i(hum_w), .b_i(h1), .shift_i(7'd19), .p_o(mh1_w));
  esc_mul u_mul_hm2 (.clk_i, .en_i(en), .a_i(hum_dly_q[S_X5-S_HUM-1]), .b_i(x5_q),
                     .shift_i(7'(FRAC_BITS)), .p_o(hum2_w));

  esc_div u_div (.clk_i, .en_i(en), .num_i(num_q), .den_i(den27_q), .quo_o(quo_w));

  // Combinational results of the simple stages
  fix_t        a0_d, b0_d, ty_s, ps_s, hm_s, pr_d;
  logic [18:0] ty_d;
  logic [24:0] pout_d;
  logic [17:0] hout_d;
  logic        quo_big;

  always_comb begin
    a0_d = ssub(fix_t'({44'd0, rt_q}) <<< (FRAC_BITS - 14),
                t1 <<< (FRAC_BITS - 10));
    b0_d = ssub(fix_t'({44'd0, rt_q}) <<< (FRAC_BITS - 17),
                t1 <<< (FRAC_BITS - 13));

    // Temperature is floor(t_fine / (5 * 2^(F+2))); the clamp to the output
    // range is applied before the divide by five, which keeps it exact.
    ty_s = tf_q >>> (FRAC_BITS + 2);
    if (ty_s < -64'sd163840) begin
      ty_d = '0;
    end else if (ty_s > 64'sd163839) begin
      ty_d = 19'd327679;
    end else begin
      ty_d = 19'(ty_s + 64'sd163840);
    end

    quo_big = |quo_w[NUM_W-1:63];
    if (!neg_dly_q[S_QUO-S_DIVST-1]) begin
      pr_d = quo_big ? FIX_MAX : fix_t'(quo_w[63:0]);
    end else begin
      pr_d = quo_big ? FIX_MIN : fix_t'(~quo_w[63:0] + 64'd1);
    end

    ps_s = ps3_q >>> (FRAC_BITS - 8);
    if (!dvld_dly_q[S_PS3-S_DIVST-1] || ps_s < 64'sd0) begin
      pout_d = '0;
    end else if (ps_s > 64'sd33554431) begin
      pout_d = '1;
    end else begin
      pout_d = ps_s[24:0];
    end

    hm_s = hum2_w >>> (FRAC_BITS - 10);
    if (hm_s < -64'sd131072) begin
      hout_d = 18'h20000;
    end else if (hm_s > 64'sd131071) begin
      hout_d = 18'h1FFFF;
    end else begin
      hout_d = hm_s[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q <= in_i.raw_temperature;
      rp_q <= in_i.raw_pressure;
      rh_q <= in_i.raw_humidity;

      // Temperature
      a0_q   <= a0_d;
      b0_q   <= b0_d;
      tf_q   <= sadd(at_dly_q[MUL_LAT-1], bt_w);
      ty_q   <= ty_d;
      tp_q   <= ty_q * 19'd419431;
      temp_q <= tp_q[36:21] - 16'd32768;

      // Pressure divisor and offset terms
      v1a_q <= ssub(tf_q >>> 1, qi(fix_t'(64000)));
      v2s_q <= sadd(v2a_w, p5m_dly_q[MUL_LAT-1]);
      v1s_q <= sadd(ap_w, p2m_dly_q[MUL_LAT-1]);
      v2_q  <= sadd(v2s_q >>> 2, qi(p4 <<< 16));
      v1t_q <= sadd(ONE, v1s_q >>> 34);
      pr0_q <= ssub(qi(fix_t'(64'd1048576 - 64'(rp_dly_q[S_V2-1]))), v2_q >>> 12);

      // Divider setup
      dvld_q  <= mag(v1_w) > DIV_THR;
      den_q   <= mag(v1_w);
      neg_q   <= pr0_dly_q[S_V1-S_PR0-1][63] ^ v1_w[63];
      pm_q    <= mag(pr0_dly_q[S_V1-S_PR0-1]);
      num_q   <= (NUM_W'(pm_q) * NUM_W'(6250)) << FRAC_BITS;
      den27_q <= den_q;

      // Pressure correction
      pr_q  <= pr_d;
      ps1_q <= sadd(aq_w, bq_dly_q[MUL_LAT-1]);
      ps2_q <= sadd(ps1_q, qi(p7));
      ps3_q <= sadd(pr_dly_q[S_PS2-S_PR-1], ps2_q >>> 4);

      // Humidity
      h_q    <= ssub(tf_q, qi(fix_t'(76800)));
      x1_q   <= sadd(qi(h4 <<< 6), mh5_w);
      x2_q   <= sadd(ONE, mh3_w);
      m6d_q  <= mh6_w;
      ha_q   <= ssub(qi(fix_t'({48'd0, rh_dly_q[S_HX1-1]})), x1_q);
      x3_q   <= sadd(ONE, mx3_w);
      x5_q   <= ssub(ONE, mh1_w);
      hout_q <= hout_d;

      // Output register
      tout_q <= signed'(tmp_dly_q[S_PS3-S_TOUT-1]);
      pout_q <= pout_d;
      pvld_q <= dvld_dly_q[S_PS3-S_DIVST-1];
      hfin_q <= signed'(hout_dly_q[S_PS3-S_HOUT-1]);

      // Delay lines
      at_dly_q[0]   <= at_w;
      p5m_dly_q[0]  <= p5m_w;
      p2m_dly_q[0]  <= p2m_w;
      bq_dly_q[0]   <= bq_w;
      for (int i = 1; i < MUL_LAT; i++) begin
        at_dly_q[i]  <= at_dly_q[i-1];
        p5m_dly_q[i] <= p5m_dly_q[i-1];
        p2m_dly_q[i] <= p2m_dly_q[i-1];
        bq_dly_q[i]  <= bq_dly_q[i-1];
      end
      rp_dly_q[0] <= rp_q;
      for (int i = 1; i < S_V2; i++) rp_dly_q[i] <= rp_dly_q[i-1];
      rh_dly_q[0] <= rh_q;
      for (int i = 1; i < S_HX1; i++) rh_dly_q[i] <= rh_dly_q[i-1];
      pr0_dly_q[0] <= pr0_q;
      for (int i = 1; i < S_V1 - S_PR0; i++) pr0_dly_q[i] <= pr0_dly_q[i-1];
      neg_dly_q[0] <= neg_q;
      for (int i = 1; i < S_QUO - S_DIVST; i++) neg_dly_q[i] <= neg_dly_q[i-1];
      dvld_dly_q[0] <= dvld_q;
      for (int i = 1; i < S_PS3 - S_DIVST; i++) dvld_dly_q[i] <= dvld_dly_q[i-1];
      pr_dly_q[0] <= pr_q;
      for (int i = 1; i < S_PS2 - S_PR; i++) pr_dly_q[i] <= pr_dly_q[i-1];
      ha_dly_q[0] <= ha_q;
      for (int i = 1; i < S_X4 - S_HA; i++) ha_dly_q[i] <= ha_dly_q[i-1];
      hum_dly_q[0] <= hum_w;
      for (int i = 1; i < S_X5 - S_HUM; i++) hum_dly_q[i] <= hum_dly_q[i-1];
      tmp_dly_q[0] <= temp_q;
      for (int i = 1; i < S_PS3 - S_TOUT; i++) tmp_dly_q[i] <= tmp_dly_q[i-1];
      hout_dly_q[0] <= hout_q;
      for (int i = 1; i < S_PS3 - S_HOUT; i++) hout_dly_q[i] <= hout_dly_q[i-1];
    end
  end

  assign out_o.temperature_out = tout_q;
  assign out_o.pressure_out    = pout_q;
  assign out_o.pressure_valid  = pvld_q;
  assign out_o.humidity_out    = hfin_q;

endmodule

// ----- hdl/esc_chk.sv -----
`include "env_sensor_compensation_defines.svh"

module esc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               cfg_valid_i,
  input logic               cfg_ready_i,
  input logic signed [15:0] temp_out_i,
  input logic [24:0]        press_out_i,
  input logic               press_valid_i,
  input logic signed [17:0] hum_out_i
);

  // A result held by the sink keeps its whole payload.
  `ESC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(temp_out_i) && $stable(press_out_i)
      && $stable(press_valid_i) && $stable(hum_out_i),
    "result changed while stalled")

  // The input side only stalls when the output register is full and held.
  `ESC_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !in_ready_i,
    out_valid_i && !out_ready_i, "input stalled without an output stall")

  `ESC_ASSERT_IMP(a_press_zero, clk_i, rst_ni, out_valid_i && !press_valid_i,
    press_out_i == 25'd0, "pressure nonzero with unusable divisor")

  `ESC_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i,
    cfg_ready_i, "configuration write not taken")

endmodule

bind env_sensor_compensation esc_chk u_esc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .temp_out_i   (out_o.temperature_out),
  .press_out_i  (out_o.pressure_out),
  .press_valid_i(out_o.pressure_valid),
  .hum_out_i    (out_o.humidity_out)
);

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

  typedef logic signed [63:0]  fx_t;
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [15:0] temperature;
    logic [24:0] pressure;
    logic        pressure_ok;
    logic [17:0] humidity;
  } reading_t;

  class comp_scoreboard;
    logic [63:0] coef_temp, coef_plow, coef_phigh, coef_p9, coef_hum;
    reading_t    awaited[$];
    int          mismatches;

    function new();
      coef_temp = '0; coef_plow = '0; coef_phigh = '0; coef_p9 = '0; coef_hum = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_TEMP:       coef_temp  = {16'd0, data[47:0]};
        REG_PRESS_LOW:  coef_plow  = data;
        REG_PRESS_HIGH: coef_phigh = data;
        REG_PRESS_NINE: coef_p9    = {48'd0, data[15:0]};
        REG_HUM:        coef_hum   = data;
        default: ;
      endcase
    endfunction

    function fx_t clip(wide_t w);
      wide_t hi, lo;
      hi = 128'sh7FFF_FFFF_FFFF_FFFF;
      lo = -hi - 1;
      if (w > hi) return fx_t'(hi);
      if (w < lo) return fx_t'(lo);
      return fx_t'(w);
    endfunction

    function fx_t mulsh(fx_t a, fx_t b, int s);
      wide_t p;
      p = wide_t'(a) * wide_t'(b);
      return clip(p >>> s);
    endfunction

    function fx_t add_s(fx_t a, fx_t b);
      return clip(wide_t'(a) + wide_t'(b));
    endfunction

    // The most negative subtrahend is negated to the most positive value.
    function fx_t sub_s(fx_t a, fx_t b);
      fx_t nb;
      nb = (b == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -b;
      return add_s(a, nb);
    endfunction

    function fx_t to_fx(fx_t k);
      return clip(wide_t'(k) <<< FB);
    endfunction

    function fx_t clamp(fx_t v, fx_t lo, fx_t hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      fx_t one, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      fx_t h1, h2, h3, h4, h5, h6, a, b, tfine, temp, v1, v2, pr, press, h, x, hum;
      wide_t td, n;
      reading_t r;
      one = fx_t'(64'd1 << FB);
      t1 = fx_t'({48'd0, coef_temp[15:0]});
      t2 = fx_t'($signed(coef_temp[31:16]));
      t3 = fx_t'($signed(coef_temp[47:32]));
      p1 = fx_t'({48'd0, coef_plow[15:0]});
      p2 = fx_t'($signed(coef_plow[31:16]));
      p3 = fx_t'($signed(coef_plow[47:32]));
      p4 = fx_t'($signed(coef_plow[63:48]));
      p5 = fx_t'($signed(coef_phigh[15:0]));
      p6 = fx_t'($signed(coef_phigh[31:16]));
      p7 = fx_t'($signed(coef_phigh[47:32]));
      p8 = fx_t'($signed(coef_phigh[63:48]));
      p9 = fx_t'($signed(coef_p9[15:0]));
      h1 = fx_t'({56'd0, coef_hum[7:0]});
      h2 = fx_t'($signed(coef_hum[23:8]));
      h3 = fx_t'({56'd0, coef_hum[31:24]});
      h4 = fx_t'($signed(coef_hum[43:32]));
      h5 = fx_t'($signed(coef_hum[55:44]));
      h6 = fx_t'($signed(coef_hum[63:56]));

      a = sub_s(mulsh(fx_t'(rt), one, 14), mulsh(t1, one, 10));
      a = mulsh(a, t2, 0);
      b = sub_s(mulsh(fx_t'(rt), one, 17), mulsh(t1, one, 13));
      b = mulsh(mulsh(b, b, FB), t3, 0);
      tfine = add_s(a, b);
      td = wide_t'(5120) <<< (FB - 8);
      if (tfine >= 0) temp = fx_t'(wide_t'(tfine) / td);
      else temp = fx_t'(-((-wide_t'(tfine) + td - 1) / td));
      temp = clamp(temp, -32768, 32767);

      v1 = sub_s(tfine >>> 1, to_fx(64000));
      v2 = mulsh(mulsh(v1, v1, FB + 15), p6, 0);
      v2 = add_s(v2, mulsh(v1, 2 * p5, 0));
      v2 = add_s(v2 >>> 2, to_fx(p4 * 65536));
      a = mulsh(mulsh(v1, v1, FB + 19), p3, 0);
      v1 = add_s(a, mulsh(v1, p2, 0)) >>> 19;
      v1 = mulsh(add_s(one, v1 >>> 15), p1, 0);
      // The divisor threshold rounds down to zero raw units.
      r.pressure_ok = (v1 != 0);
      press = 0;
      if (r.pressure_ok) begin
        pr = sub_s(to_fx(1048576 - fx_t'(rp)), v2 >>> 12);
        n = wide_t'(pr) * (wide_t'(6250) <<< FB);
        pr = clip(n / wide_t'(v1));
        a = mulsh(mulsh(pr, pr, FB + 31), p9, 0);
        b = mulsh(pr, p8, 15);
        press = add_s(pr, add_s(add_s(a, b), to_fx(p7)) >>> 4);
        press = clamp(press >>> (FB - 8), 0, 33554431);
      end

      h = sub_s(tfine, to_fx(76800));
      x = add_s(to_fx(h4 * 64), mulsh(h, h5, 14));
      a = sub_s(to_fx(fx_t'(rh)), x);
      x = add_s(one, mulsh(h, h3, 26));
      x = add_s(one, mulsh(mulsh(h, h6, 26), x, FB));
      x = mulsh(x, h2, 16);
      hum = mulsh(a, x, FB);
      x = sub_s(one, mulsh(hum, h1, 19));
      hum = mulsh(hum, x, FB);
      hum = clamp(hum >>> (FB - 10), -131072, 131071);

      r.temperature = temp[15:0];
      r.pressure    = press[24:0];
      r.humidity    = hum[17:0];
      return r;
    endfunction

    function void note_input(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      awaited.push_back(compensate(rt, rp, rh));
    endfunction

    function void check(reading_t got);
      reading_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: T exp %h got %h, P exp %h got %h, PV exp %b got %b, H exp %h got %h",
                   want.temperature, got.temperature, want.pressure, got.pressure,
                   want.pressure_ok, got.pressure_ok, want.humidity, got.humidity);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  esc_cfg_if cfg_ch();
  esc_in_if  in_ch();
  esc_out_if out_ch();

  env_sensor_compensation uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  comp_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    cfg_ch.valid <= 1'b0; cfg_ch.index <= '0; cfg_ch.data <= '0;
    in_ch.valid <= 1'b0; in_ch.raw_temperature <= '0;
    in_ch.raw_pressure <= '0; in_ch.raw_humidity <= '0;
  end

  // Result side: checks every transfer and paces ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check({out_ch.temperature_out, out_ch.pressure_out, out_ch.pressure_valid,
                  out_ch.humidity_out});
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure <= rp;
    in_ch.raw_humidity <= rh;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(rt, rp, rh);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_slice();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic logic [15:0] jit(int base, int spread);
    return 16'(base + $urandom_range(2 * spread) - spread);
  endfunction

  // Kind 0: coefficients near a real part, 1: fully random, 2: range corners.
  task automatic load_coeffs(int kind);
    logic [63:0] r[5];
    if (kind == 0) begin
      r[0] = {16'd0, jit(-1000, 300), jit(26435, 2000), jit(27504, 2000)};
      r[1] = {jit(2855, 500), jit(3024, 500), jit(-10685, 1000), jit(36477, 3000)};
      r[2] = {jit(-14600, 1000), jit(15500, 1000), jit(-7, 7), jit(140, 60)};
      r[3] = 64'($signed(jit(6000, 500)));
      r[4] = {8'(jit(30, 10)), 12'(jit(50, 20)), 12'(jit(313, 50)), 8'd0,
              jit(362, 50), 8'(jit(75, 10))};
    end else if (kind == 1) begin
      foreach (r[i]) r[i] = {$urandom, $urandom};
      r[0][63:48] = '0;
      r[3] = 64'($signed(r[3][15:0]));
    end else begin
      foreach (r[i]) r[i] = {edge_slice(), edge_slice(), edge_slice(), edge_slice()};
      r[0][63:48] = '0;
      r[3] = 64'($signed(r[3][15:0]));
    end
    write_reg(REG_TEMP, r[0]);
    write_reg(REG_PRESS_LOW, r[1]);
    write_reg(REG_PRESS_HIGH, r[2]);
    write_reg(REG_PRESS_NINE, r[3]);
    write_reg(REG_HUM, r[4]);
  endtask

  task automatic random_readings(int count);
    repeat (count) begin
      if ($urandom_range(1))
        send_reading(20'($urandom), 20'($urandom), 16'($urandom));
      else
        send_reading(20'(519888 + $urandom_range(131072) - 65536),
                     20'(415148 + $urandom_range(131072) - 65536),
                     16'(27000 + $urandom_range(16384) - 8192));
    end
  endtask

  initial begin
    logic [19:0] corner20[3];
    logic [15:0] corner16[3];
    corner20 = '{20'h00000, 20'hFFFFF, 20'h80000};
    corner16 = '{16'h0000, 16'hFFFF, 16'h8000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: the pressure divisor is zero.
    send_reading(20'd519888, 20'd415148, 16'd27000);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();

    load_coeffs(0);
    for (int i = IDX_SPARE_FIRST; i <= IDX_SPARE_LAST; i++)
      write_reg(CFG_IDX_W'(i), 64'hDEAD_BEEF_0BAD_F00D);
    foreach (corner20[i])
      foreach (corner20[j])
        send_reading(corner20[i], corner20[j], corner16[(i + j) % 3]);
    send_reading(20'd519888, 20'd415148, 16'd27000);
    send_reading(20'd519888, 20'd0, 16'd0);
    drain();

    // A zero p1 leaves no usable pressure divisor.
    write_reg(REG_PRESS_LOW, 64'h0B27_0BD0_D643_0000);
    send_reading(20'd519888, 20'd415148, 16'd27000);
    send_reading(20'd0, 20'hFFFFF, 16'hFFFF);
    drain();

    write_reg(REG_TEMP, 64'h0000_7FFF_7FFF_FFFF);
    write_reg(REG_PRESS_LOW, 64'h7FFF_7FFF_7FFF_FFFF);
    write_reg(REG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_PRESS_NINE, 64'h0000_0000_0000_7FFF);
    write_reg(REG_HUM, 64'h7F7F_F7FF_FF7F_FFFF);
    send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
    send_reading(20'd0, 20'hFFFFF, 16'd0);
    drain();
    write_reg(REG_TEMP, 64'h0000_8000_8000_0000);
    write_reg(REG_PRESS_LOW, 64'h8000_8000_8000_0001);
    write_reg(REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
    write_reg(REG_PRESS_NINE, 64'hFFFF_FFFF_FFFF_8000);
    write_reg(REG_HUM, 64'h8080_0800_0000_8000);
    send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
    send_reading(20'd0, 20'hFFFFF, 16'd0);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      load_coeffs((ph % 5 == 4) ? 2 : ((ph % 3 == 2) ? 1 : 0));
      // Long receiver hold-off while items keep coming: the pipeline fills.
      if (ph == 4) hold_cycles = 400;
      random_readings(110);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
